// ===== sv/salc_pkg.sv =====
// shared constants and control types for the set-associative lru cache tag simulator
// used by the channel interfaces, the controller, the datapath and the top level
package salc_pkg;

   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 7;
   localparam int COUNT_W = 32;

   localparam int SETS_DEFAULT       = 64;
   localparam int WAYS_DEFAULT       = 4;
   localparam int LINE_BYTES_DEFAULT = 64;
   localparam int ADDR_BITS_DEFAULT  = 32;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic write_row;
      logic use_second;
      logic read_second;
      logic save_first;
      logic publish;
   } salc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic straddle;
      logic span_err;
   } salc_stat_type;

endpackage

// ===== sv/salc_channels.sv =====
// valid/ready channel interfaces for memory references and lookup results
// depends on salc_pkg for the payload widths
interface salc_req_if;
   import salc_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   logic [SIZE_W-1:0] access_size;

   modport source (output valid, output address, output access_size, input ready);
   modport sink   (input valid, input address, input access_size, output ready);
endinterface

interface salc_rsp_if;
   import salc_pkg::*;

   logic               valid;
   logic               ready;
   logic               miss;
   logic               straddled;
   logic               span_error;
   logic [COUNT_W-1:0] access_total;
   logic [COUNT_W-1:0] miss_total;

   modport source (output valid, output miss, output straddled, output span_error,
                   output access_total, output miss_total, input ready);
   modport sink   (input valid, input miss, input straddled, input span_error,
                   input access_total, input miss_total, output ready);
endinterface

// ===== sv/salc_ctrl.sv =====
// sequencing of one reference: accept, first row lookup, optional second row lookup
// depends on salc_pkg for the command and status structs
module salc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  salc_pkg::salc_stat_type stat,
   output salc_pkg::salc_cmd_type  cmd
);
   import salc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK1,
      ST_LOOK2
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_LOOK1;
            end
         end
         ST_LOOK1: begin
            if (stat.straddle) begin
               // first row written back while the second row is read
               cmd.write_row   = 1'b1;
               cmd.read_second = 1'b1;
               cmd.save_first  = 1'b1;
               state_in        = ST_LOOK2;
            end else if (out_free) begin
               cmd.write_row = !stat.span_err;
               cmd.publish   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LOOK2: begin
            cmd.use_second = 1'b1;
            if (out_free) begin
               cmd.write_row = 1'b1;
               cmd.publish   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/salc_dpath.sv =====
// tag store memory in mru-to-lru row order, lookup and reorder logic, counters
// depends on salc_pkg; driven by salc_ctrl commands
module salc_dpath #(
   parameter int SETS       = salc_pkg::SETS_DEFAULT,
   parameter int WAYS       = salc_pkg::WAYS_DEFAULT,
   parameter int LINE_BYTES = salc_pkg::LINE_BYTES_DEFAULT,
   parameter int ADDR_BITS  = salc_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  salc_pkg::salc_cmd_type        cmd,
   output salc_pkg::salc_stat_type       stat,
   input  logic [salc_pkg::ADDR_W-1:0]   req_address,
   input  logic [salc_pkg::SIZE_W-1:0]   req_access_size,
   output logic                          rsp_miss,
   output logic                          rsp_straddled,
   output logic                          rsp_span_error,
   output logic [salc_pkg::COUNT_W-1:0]  rsp_access_total,
   output logic [salc_pkg::COUNT_W-1:0]  rsp_miss_total
);
   import salc_pkg::*;

   // non power of two sizes act as the largest power of two below them
   localparam int OFF_W     = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_W     = $clog2(SETS + 1) - 1;
   localparam int SET_IW    = (SET_W > 0) ? SET_W : 1;
   localparam int ROWS      = 1 << SET_W;
   localparam int TAG_LSB   = OFF_W + SET_W;
   localparam int TAG_W     = (ADDR_BITS > TAG_LSB) ? (ADDR_BITS - TAG_LSB) : 1;
   localparam int WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [SET_IW-1:0] SET_MASK = SET_IW'((1 << SET_W) - 1);

   typedef logic [WAYS-1:0][TAG_W-1:0] row_type;

   row_type                  tag_ram [ROWS];
   logic [ROWS-1:0]          row_valid_ff;
   row_type                  rd_row_ff;
   logic                     rd_valid_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [SIZE_W-1:0]        size_ff;
   logic                     miss1_ff;
   logic                     miss_ff;
   logic                     straddled_ff;
   logic                     span_error_ff;
   logic [COUNT_W-1:0]       access_cnt_ff;
   logic [COUNT_W-1:0]       miss_cnt_ff;

   logic [ADDR_BITS+ADDR_W-1:0] req_wide;
   logic [ADDR_BITS-1:0]     req_addr;
   logic [ADDR_BITS-1:0]     req_shift;
   logic [SET_IW-1:0]        req_set;
   logic [SIZE_W-1:0]        size_eff;
   logic [ADDR_BITS-1:0]     last_addr;
   logic [ADDR_BITS-1:0]     sh1;
   logic [ADDR_BITS-1:0]     sh2;
   logic [ADDR_BITS-1:0]     tsh1;
   logic [ADDR_BITS-1:0]     tsh2;
   logic [SET_IW-1:0]        set1;
   logic [SET_IW-1:0]        set2;
   logic [SET_IW-1:0]        set1_next;
   logic [TAG_W-1:0]         tag1;
   logic [TAG_W-1:0]         tag2;
   logic [TAG_W-1:0]         tag_sel;
   logic [SET_IW-1:0]        set_sel;
   logic [SET_IW-1:0]        rd_addr;
   logic                     rd_en;
   row_type                  cur_row;
   row_type                  new_row;
   logic                     found;
   logic [WAY_IW-1:0]        hit_way;
   logic                     lookup_miss;
   logic                     pub_miss;

   // address cut or zero-extended to the configured address width
   assign req_wide  = {{ADDR_BITS{1'b0}}, req_address};
   assign req_addr  = req_wide[ADDR_BITS-1:0];
   assign req_shift = req_addr >> OFF_W;
   assign req_set   = req_shift[SET_IW-1:0] & SET_MASK;
   assign size_eff  = (req_access_size == '0) ? SIZE_W'(1) : req_access_size;

   assign last_addr = addr_ff + {{(ADDR_BITS-SIZE_W){1'b0}}, size_ff} - ADDR_BITS'(1);
   assign sh1       = addr_ff >> OFF_W;
   assign sh2       = last_addr >> OFF_W;
   assign set1      = sh1[SET_IW-1:0] & SET_MASK;
   assign set2      = sh2[SET_IW-1:0] & SET_MASK;
   assign set1_next = (set1 + SET_IW'(1)) & SET_MASK;
   assign tsh1      = addr_ff >> TAG_LSB;
   assign tsh2      = last_addr >> TAG_LSB;
   assign tag1      = tsh1[TAG_W-1:0];
   assign tag2      = tsh2[TAG_W-1:0];

   assign stat.straddle = (set1 != set2) && (set1_next == set2);
   assign stat.span_err = (set1 != set2) && (set1_next != set2);

   assign tag_sel = cmd.use_second ? tag2 : tag1;
   assign set_sel = cmd.use_second ? set2 : set1;
   assign rd_en   = cmd.accept || cmd.read_second;
   assign rd_addr = cmd.accept ? req_set : set2;

   // rows never written since reset read as all-zero tags
   assign cur_row = rd_valid_ff ? rd_row_ff : '0;

   always_comb begin
      found   = 1'b0;
      hit_way = WAY_IW'(WAYS - 1);
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (cur_row[i] == tag_sel) begin
            found   = 1'b1;
            hit_way = WAY_IW'(i);
         end
      end
   end

   assign lookup_miss = !found;

   // hit tag, or on a miss the new tag, moves to mru, younger tags shift down one way
   always_comb begin
      new_row    = cur_row;
      new_row[0] = tag_sel;
      for (int j = 1; j < WAYS; j++) begin
         if (WAY_IW'(j) <= hit_way) begin
            new_row[j] = cur_row[j-1];
         end
      end
   end

   always_comb begin
      if (cmd.use_second) begin
         pub_miss = miss1_ff || lookup_miss;
      end else begin
         pub_miss = !stat.span_err && lookup_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_row) begin
         tag_ram[set_sel] <= new_row;
      end
      if (rd_en) begin
         rd_row_ff <= tag_ram[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_addr;
         size_ff <= size_eff;
      end
      if (cmd.save_first) begin
         miss1_ff <= lookup_miss;
      end
      if (cmd.publish) begin
         miss_ff       <= pub_miss;
         straddled_ff  <= cmd.use_second;
         span_error_ff <= !cmd.use_second && stat.span_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         access_cnt_ff <= '0;
         miss_cnt_ff   <= '0;
      end else begin
         if (cmd.write_row) begin
            row_valid_ff[set_sel] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (cmd.publish) begin
            access_cnt_ff <= access_cnt_ff + COUNT_W'(1);
            miss_cnt_ff   <= miss_cnt_ff + COUNT_W'(pub_miss);
         end
      end
   end

   assign rsp_miss         = miss_ff;
   assign rsp_straddled    = straddled_ff;
   assign rsp_span_error   = span_error_ff;
   assign rsp_access_total = access_cnt_ff;
   assign rsp_miss_total   = miss_cnt_ff;

endmodule

// ===== sv/set_assoc_lru_cache_tag_sim.sv =====
// Set-associative LRU cache tag simulator. Each request transaction carries one memory
// reference (byte address, byte count); each produces exactly one response transaction
// with the miss flag, straddle and span-error flags and the running access and miss
// counts (both wrap). The tag store is one memory holding a whole set row (all ways, in
// MRU-to-LRU order) per entry, read and written one row per cycle; per-row valid bits
// cleared at reset make untouched rows read as all-zero tags, so no clearing pass is
// needed and the block is ready right after reset. A reference within one set, or one
// rejected as a span error, takes one row lookup; one straddling two adjacent sets takes
// one row read-modify-write per set, the first row written back while the second is
// read. The result sits in an output register, so a new request is accepted while the
// previous result waits; the final step of the next reference holds until that result is taken.
// depends on salc_pkg, salc_channels, salc_ctrl and salc_dpath
module set_assoc_lru_cache_tag_sim #(
   parameter int SETS       = salc_pkg::SETS_DEFAULT,
   parameter int WAYS       = salc_pkg::WAYS_DEFAULT,
   parameter int LINE_BYTES = salc_pkg::LINE_BYTES_DEFAULT,
   parameter int ADDR_BITS  = salc_pkg::ADDR_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   salc_req_if.sink  req_ch,
   salc_rsp_if.source rsp_ch
);
   import salc_pkg::*;

   salc_cmd_type  cmd;
   salc_stat_type stat;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   salc_dpath #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_address      (req_ch.address),
      .req_access_size  (req_ch.access_size),
      .rsp_miss         (rsp_ch.miss),
      .rsp_straddled    (rsp_ch.straddled),
      .rsp_span_error   (rsp_ch.span_error),
      .rsp_access_total (rsp_ch.access_total),
      .rsp_miss_total   (rsp_ch.miss_total)
   );

endmodule

// ===== sim/set_assoc_lru_cache_tag_sim_test.sv =====
// self-checking bench for the set-associative lru cache tag simulator: drives memory references,
// predicts miss/straddle/span flags and running counts, and checks every response transaction
// depends on salc_pkg, salc_channels and set_assoc_lru_cache_tag_sim
module set_assoc_lru_cache_tag_sim_test;
   import salc_pkg::*;

   localparam int OFF_BITS   = $clog2(LINE_BYTES_DEFAULT);
   localparam int SET_BITS   = $clog2(SETS_DEFAULT);
   localparam int TAG_W      = ADDR_W - OFF_BITS - SET_BITS;
   localparam int STALL_MAX  = 17;
   localparam int IDLE_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic               miss;
      logic               straddled;
      logic               span_error;
      logic [COUNT_W-1:0] access_total;
      logic [COUNT_W-1:0] miss_total;
   } lookup_result_type;

   logic clock;
   logic reset;

   salc_req_if req_ch ();
   salc_rsp_if rsp_ch ();

   set_assoc_lru_cache_tag_sim dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicted tag store, way 0 is most recently used
   logic [TAG_W-1:0]   tag_rows [SETS_DEFAULT][WAYS_DEFAULT];
   logic [COUNT_W-1:0] access_count;
   logic [COUNT_W-1:0] miss_count;
   lookup_result_type  pending_results [$];

   logic [TAG_W-1:0] hot_tags [8];

   bit          idle_on;
   int unsigned stall_left;
   int unsigned idle_cycles;
   int unsigned mismatch_count;
   int unsigned reference_count;
   int unsigned predicted_misses;
   int unsigned predicted_straddles;
   int unsigned predicted_span_errors;

   always #1 clock = ~clock;

   // returns 1 on a miss and moves the tag to the mru way either way
   function automatic bit touch_set_row(input logic [SET_BITS-1:0] set_idx,
                                        input logic [TAG_W-1:0] tag);
      int hit_way;
      bit missed;
      hit_way = WAYS_DEFAULT - 1;
      missed  = 1'b1;
      for (int w = 0; w < WAYS_DEFAULT; w++) begin
         if (missed && tag_rows[set_idx][w] == tag) begin
            hit_way = w;
            missed  = 1'b0;
         end
      end
      for (int w = hit_way; w > 0; w--)
         tag_rows[set_idx][w] = tag_rows[set_idx][w-1];
      tag_rows[set_idx][0] = tag;
      return missed;
   endfunction

   function automatic void compute_lookup_result(input logic [ADDR_W-1:0] addr,
                                                 input logic [SIZE_W-1:0] size);
      logic [ADDR_W-1:0]   last_byte;
      logic [SET_BITS-1:0] first_set;
      logic [SET_BITS-1:0] last_set;
      logic [SET_BITS-1:0] next_set;
      lookup_result_type   res;
      bit                  m1;
      bit                  m2;
      res = '0;
      // zero size counts as one byte
      last_byte = addr + ((size == '0) ? ADDR_W'(0) : ADDR_W'(size) - ADDR_W'(1));
      first_set = addr[OFF_BITS +: SET_BITS];
      last_set  = last_byte[OFF_BITS +: SET_BITS];
      next_set  = first_set + SET_BITS'(1);
      access_count = access_count + COUNT_W'(1);
      if (first_set == last_set) begin
         res.miss = touch_set_row(first_set, addr[ADDR_W-1 -: TAG_W]);
      end else if (next_set == last_set) begin
         m1 = touch_set_row(first_set, addr[ADDR_W-1 -: TAG_W]);
         m2 = touch_set_row(last_set, last_byte[ADDR_W-1 -: TAG_W]);
         res.miss      = m1 | m2;
         res.straddled = 1'b1;
         predicted_straddles++;
      end else begin
         res.span_error = 1'b1;
         predicted_span_errors++;
      end
      if (res.miss) begin
         miss_count = miss_count + COUNT_W'(1);
         predicted_misses++;
      end
      res.access_total = access_count;
      res.miss_total   = miss_count;
      pending_results.push_back(res);
      reference_count++;
   endfunction

   task automatic send_reference(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, STALL_MAX)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.address     <= addr;
      req_ch.access_size <= size;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      // ready is stable here, so the transaction completes at the next rising edge
      compute_lookup_result(addr, size);
      @(posedge clock);
   endtask

   function automatic void pick_reference(output logic [ADDR_W-1:0] addr,
                                          output logic [SIZE_W-1:0] size);
      int unsigned kind;
      logic [SET_BITS-1:0] set_idx;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // reuse a few tags on a few sets so hits, evictions and straddles are frequent
         case ($urandom_range(0, 4))
            0: set_idx = '0;
            1: set_idx = SET_BITS'(1);
            2: set_idx = '1;
            3: set_idx = SET_BITS'(SETS_DEFAULT / 2);
            default: set_idx = SET_BITS'($urandom);
         endcase
         addr = {hot_tags[$urandom_range(0, 7)], set_idx, OFF_BITS'($urandom)};
         size = SIZE_W'($urandom_range(1, LINE_BYTES_DEFAULT));
      end else if (kind < 85) begin
         addr = $urandom;
         size = SIZE_W'($urandom_range(1, LINE_BYTES_DEFAULT));
      end else begin
         addr = $urandom;
         size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
      end
   endfunction

   task automatic test_fresh_store;
      // cleared store holds tag zero in every way
      send_reference(32'h0000_0000, 7'd1);
      send_reference(32'h0000_0FC0, 7'd1);
   endtask

   task automatic test_field_extremes;
      send_reference(32'hFFFF_FFFF, 7'd1);
      send_reference(32'hFFFF_FFFF, 7'd2);
      send_reference(32'hFFFF_FFC0, 7'd64);
      send_reference(32'h1234_5678, 7'd0);
      send_reference(32'h0000_0000, 7'd127);
      send_reference(32'h2AAA_AAAA, 7'h55);
      send_reference(32'h5555_5555, 7'h2A);
   endtask

   task automatic test_straddle_and_span;
      send_reference(32'h0000_1001, 7'd64);
      send_reference(32'h0000_203F, 7'd65);
      send_reference(32'h0000_203F, 7'd66);
      send_reference(32'h0000_303F, 7'd127);
      // last byte wraps past the top of the address space
      send_reference(32'hFFFF_FFC1, 7'd64);
   endtask

   task automatic test_lru_order;
      logic [SET_BITS-1:0] set_idx;
      set_idx = SET_BITS'(5);
      for (int t = 1; t <= 4; t++)
         send_reference({TAG_W'(t), set_idx, OFF_BITS'(0)}, 7'd4);
      send_reference({TAG_W'(1), set_idx, OFF_BITS'(8)}, 7'd4);
      // tag 2 is now lru and gets evicted
      send_reference({TAG_W'(5), set_idx, OFF_BITS'(0)}, 7'd4);
      send_reference({TAG_W'(2), set_idx, OFF_BITS'(0)}, 7'd4);
      send_reference({TAG_W'(1), set_idx, OFF_BITS'(0)}, 7'd4);
   endtask

   task automatic test_random_mix(input int unsigned count);
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      hot_tags[0] = '0;
      hot_tags[1] = '1;
      for (int i = 2; i < 8; i++) hot_tags[i] = TAG_W'($urandom);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 200 == 199) hot_tags[$urandom_range(2, 7)] = TAG_W'($urandom);
         pick_reference(addr, size);
         send_reference(addr, size);
      end
   endtask

   task automatic test_random_steady(input int unsigned count);
      idle_on = 1'b0;
      test_random_mix(count);
   endtask

   task automatic check_field(input string field, input logic [COUNT_W-1:0] exp_val,
                              input logic [COUNT_W-1:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", field, exp_val, act_val);
      end
   endtask

   // response checker and watchdog, both sampled away from the driving edge
   always @(negedge clock) begin
      lookup_result_type exp_res;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response transaction: access_total %0h",
                           rsp_ch.access_total);
            end else begin
               exp_res = pending_results.pop_front();
               check_field("miss", COUNT_W'(exp_res.miss), COUNT_W'(rsp_ch.miss));
               check_field("straddled", COUNT_W'(exp_res.straddled),
                           COUNT_W'(rsp_ch.straddled));
               check_field("span_error", COUNT_W'(exp_res.span_error),
                           COUNT_W'(rsp_ch.span_error));
               check_field("access_total", exp_res.access_total, rsp_ch.access_total);
               check_field("miss_total", exp_res.miss_total, rsp_ch.miss_total);
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("set_assoc_lru_cache_tag_sim test failed");
            $finish;
         end
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left   <= $urandom_range(1, STALL_MAX) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.address     = '0;
      req_ch.access_size = '0;
      idle_on            = 1'b1;
      access_count       = '0;
      miss_count         = '0;
      for (int s = 0; s < SETS_DEFAULT; s++)
         for (int w = 0; w < WAYS_DEFAULT; w++)
            tag_rows[s][w] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fresh_store();
      test_field_extremes();
      test_straddle_and_span();
      test_lru_order();
      test_random_mix(1480);
      test_random_steady(350);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d references: %0d misses, %0d straddling, %0d span errors",
               reference_count, predicted_misses, predicted_straddles, predicted_span_errors);
      if (mismatch_count == 0) begin
         $display("set_assoc_lru_cache_tag_sim test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("set_assoc_lru_cache_tag_sim test failed");
      end
      $finish;
   end

endmodule
